// ===== rtl/fep_pkg.sv =====
// Package for the flat-earth phase block: configuration register indexes,
// register reset values and stream widths. No dependencies.
package fep_pkg;

    // Configuration register indexes, in register-map order
    typedef enum logic [2:0] {
        CFG_PIXEL_SPACING       = 3'd0,
        CFG_CENTER_OFFSET       = 3'd1,
        CFG_GROUND_RANGE_FIRST  = 3'd2,
        CFG_HEIGHT_FIRST        = 3'd3,
        CFG_GROUND_RANGE_SECOND = 3'd4,
        CFG_HEIGHT_SECOND       = 3'd5,
        CFG_PHASE_SCALE         = 3'd6
    } t_cfg_idx;

    localparam int CFG_DATA_W  = 48;
    localparam int SPACING_W   = 32;
    localparam int DIST_W      = 48;
    localparam int SCALE_HALF  = 24;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 32'd65536;

endpackage

// ===== rtl/fep_isqrt.sv =====
// Pipelined integer square root, one result bit per stage (restoring form).
// Does not use fep_pkg, but shares its house style; no dependencies.
module fep_isqrt #(
    parameter int ROOT_W = 50
) (
    input  logic                  i_clk,
    input  logic [ROOT_W-1:0]     i_en,
    input  logic [2*ROOT_W-1:0]   i_radicand,
    output logic [ROOT_W-1:0]     o_root
);

    logic [ROOT_W+1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [2*ROOT_W-1:0] r_num  [ROOT_W];

    genvar j;
    generate
        for (j = 0; j < ROOT_W; j++) begin : g_step
            logic [ROOT_W+1:0]   prev_rem;
            logic [ROOT_W-1:0]   prev_root;
            logic [2*ROOT_W-1:0] prev_num;
            logic [ROOT_W+1:0]   rem_sh;
            logic [ROOT_W+1:0]   trial;
            logic                ge;

            // select the previous stage, or the fresh radicand
            if (j == 0) begin : g_first
                assign prev_rem  = '0;
                assign prev_root = '0;
                assign prev_num  = i_radicand;
            end else begin : g_next
                assign prev_rem  = r_rem[j-1];
                assign prev_root = r_root[j-1];
                assign prev_num  = r_num[j-1];
            end

            // bring down two bits and try the next root bit
            assign rem_sh = {prev_rem[ROOT_W-1:0], prev_num[2*ROOT_W-1 -: 2]};
            assign trial  = {prev_root, 2'b01};
            assign ge     = (rem_sh >= trial);

            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j]  <= ge ? (rem_sh - trial) : rem_sh;
                    r_root[j] <= {prev_root[ROOT_W-2:0], ge};
                    r_num[j]  <= {prev_num[2*ROOT_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign o_root = r_root[ROOT_W-1];

endmodule

// ===== rtl/flat_earth_phase_per_column.sv =====
// Flat-earth interferometric phase per column, fully pipelined.
// The pipeline holds ten arithmetic stages plus one stage per slant-range root bit.
// Throughput: one column per cycle unless the output stalls; each stage moves on when the next has room.
// Reset (i_rst_n low, synchronous) empties the pipeline and restores registers.
module flat_earth_phase_per_column #(
    parameter int COLUMN_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  fep_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [fep_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [fep_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,   // [15:0] column_index
    // output stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [fep_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata    // [15:0] wrapped_phase
);

    localparam int PW  = COLUMN_BITS + 32;
    localparam int YW  = ((PW > 48) ? PW : 48) + 1;
    localparam int VW  = YW + 1;
    localparam int AW  = YW;
    localparam int K   = (AW + 1) / 2;
    localparam int KH  = AW - K;
    localparam int SQW = 2 * AW;
    localparam int RW  = AW + 1;
    localparam int NW  = 2 * RW;
    localparam int SHO = FRACTION_BITS + 16;
    localparam int M   = SHO + 16;
    localparam int DW  = ((RW + 1) > M) ? (RW + 1) : M;
    localparam int K2  = (M + 1) / 2;
    localparam int SH  = fep_pkg::SCALE_HALF;
    localparam int PPW = M + 2 * SH;
    localparam int NS  = RW + 10;
    localparam int OUT_W_LOCAL = fep_pkg::OUT_TDATA_W;

    // configuration registers
    logic [fep_pkg::SPACING_W-1:0]    r_spacing;
    logic [fep_pkg::DIST_W-1:0]       r_center;
    logic signed [fep_pkg::DIST_W-1:0] r_g [2];
    logic [fep_pkg::DIST_W-1:0]       r_h [2];
    logic [fep_pkg::DIST_W-1:0]       r_scale;

    // write one configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= fep_pkg::SPACING_RESET;
            r_center  <= '0;
            r_g[0]    <= '0;
            r_h[0]    <= '0;
            r_g[1]    <= '0;
            r_h[1]    <= '0;
            r_scale   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fep_pkg::CFG_PIXEL_SPACING:       r_spacing <= i_cfg_data[fep_pkg::SPACING_W-1:0];
                fep_pkg::CFG_CENTER_OFFSET:       r_center  <= i_cfg_data;
                fep_pkg::CFG_GROUND_RANGE_FIRST:  r_g[0]    <= i_cfg_data;
                fep_pkg::CFG_HEIGHT_FIRST:        r_h[0]    <= i_cfg_data;
                fep_pkg::CFG_GROUND_RANGE_SECOND: r_g[1]    <= i_cfg_data;
                fep_pkg::CFG_HEIGHT_SECOND:       r_h[1]    <= i_cfg_data;
                fep_pkg::CFG_PHASE_SCALE:         r_scale   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits and per-stage advance: a stage moves when empty or its successor moves
    logic [NS:1]   r_v;
    logic [NS+1:1] adv;

    assign adv[NS+1] = i_m_axis_tready;
    genvar k;
    generate
        for (k = 1; k <= NS; k++) begin : g_adv
            assign adv[k] = !r_v[k] || adv[k+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[1]) begin
                r_v[1] <= i_s_axis_tvalid;
            end
            for (int s = 2; s <= NS; s++) begin
                if (adv[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    assign o_s_axis_tready = adv[1];
    assign o_m_axis_tvalid = r_v[NS];

    // stage 1: column times spacing
    logic [COLUMN_BITS-1:0] col;
    logic [PW-1:0]          n_prod;
    logic [PW-1:0]          r_prod;
    assign col    = COLUMN_BITS'(i_s_axis_tdata);
    assign n_prod = col * r_spacing;
    always_ff @(posedge i_clk) begin
        if (adv[1]) r_prod <= n_prod;
    end

    // stage 2: ground offset from center
    logic signed [YW-1:0] r_y;
    always_ff @(posedge i_clk) begin
        if (adv[2]) r_y <= YW'(r_prod) - YW'(r_center);
    end

    // stage 3: offset plus antenna ground range
    logic signed [VW-1:0] r_gv [2];
    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_gv[0] <= VW'(r_y) + VW'(r_g[0]);
            r_gv[1] <= VW'(r_y) + VW'(r_g[1]);
        end
    end

    // stage 4: magnitude of the horizontal leg
    logic [AW-1:0] r_a [2];
    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_a[0] <= r_gv[0][VW-1] ? AW'(-r_gv[0]) : AW'(r_gv[0]);
            r_a[1] <= r_gv[1][VW-1] ? AW'(-r_gv[1]) : AW'(r_gv[1]);
        end
    end

    // stages 5 and 6: squares of both legs of both antennas, split in halves
    logic [AW-1:0]     sq_op  [4];
    logic [2*KH-1:0]   r_p_hh [4];
    logic [KH+K-1:0]   r_p_hl [4];
    logic [2*K-1:0]    r_p_ll [4];
    logic [SQW-1:0]    r_sq   [4];

    assign sq_op[0] = r_a[0];
    assign sq_op[1] = r_a[1];
    assign sq_op[2] = AW'(r_h[0]);
    assign sq_op[3] = AW'(r_h[1]);

    generate
        for (k = 0; k < 4; k++) begin : g_sq
            logic [KH-1:0] op_hi;
            logic [K-1:0]  op_lo;
            assign op_hi = sq_op[k][AW-1:K];
            assign op_lo = sq_op[k][K-1:0];

            always_ff @(posedge i_clk) begin
                if (adv[5]) begin
                    r_p_hh[k] <= op_hi * op_hi;
                    r_p_hl[k] <= op_hi * op_lo;
                    r_p_ll[k] <= op_lo * op_lo;
                end
                if (adv[6]) begin
                    r_sq[k] <= (SQW'(r_p_hh[k]) << (2 * K))
                             + (SQW'(r_p_hl[k]) << (K + 1))
                             + SQW'(r_p_ll[k]);
                end
            end
        end
    endgenerate

    // stage 7: squared slant ranges
    logic [NW-1:0] r_n [2];
    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_n[0] <= NW'(r_sq[0]) + NW'(r_sq[2]);
            r_n[1] <= NW'(r_sq[1]) + NW'(r_sq[3]);
        end
    end

    // stages 8 .. RW+7: slant ranges, one root bit per stage
    logic [RW-1:0] root [2];
    fep_isqrt #(.ROOT_W(RW)) u_isqrt_first (
        .i_clk      (i_clk),
        .i_en       (adv[RW+7:8]),
        .i_radicand (r_n[0]),
        .o_root     (root[0])
    );
    fep_isqrt #(.ROOT_W(RW)) u_isqrt_second (
        .i_clk      (i_clk),
        .i_en       (adv[RW+7:8]),
        .i_radicand (r_n[1]),
        .o_root     (root[1])
    );

    // stage RW+8: range difference, two's complement
    logic [DW-1:0] r_d;
    always_ff @(posedge i_clk) begin
        if (adv[RW+8]) r_d <= DW'(root[0]) - DW'(root[1]);
    end

    // stage RW+9: partial products of difference times scale, modulo 2^M
    logic [K2-1:0]       d_lo;
    logic [M-K2-1:0]     d_hi;
    logic [SH-1:0]       s_lo;
    logic [SH-1:0]       s_hi;
    logic [K2+SH-1:0]    r_m_ll;
    logic [K2+SH-1:0]    r_m_lh;
    logic [M-K2+SH-1:0]  r_m_hl;
    logic [M-K2+SH-1:0]  r_m_hh;
    assign d_lo = r_d[K2-1:0];
    assign d_hi = r_d[M-1:K2];
    assign s_lo = r_scale[SH-1:0];
    assign s_hi = r_scale[2*SH-1:SH];
    always_ff @(posedge i_clk) begin
        if (adv[RW+9]) begin
            r_m_ll <= d_lo * s_lo;
            r_m_lh <= d_lo * s_hi;
            r_m_hl <= d_hi * s_lo;
            r_m_hh <= d_hi * s_hi;
        end
    end

    // stage RW+10: sum the partials and keep the turn fraction
    logic [M-1:0] n_p;
    logic [OUT_W_LOCAL-1:0] r_out;
    assign n_p = M'(PPW'(r_m_ll))
               + M'(PPW'(r_m_lh) << SH)
               + M'(PPW'(r_m_hl) << K2)
               + M'(PPW'(r_m_hh) << (K2 + SH));
    always_ff @(posedge i_clk) begin
        if (adv[NS]) r_out <= n_p[M-1:SHO];
    end
    assign o_m_axis_tdata = r_out;

    // a taken result frees the whole pipeline, so the input side opens
    a_out_frees_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input blocked while output drains");

    // an accepted transaction occupies the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_v[1])
        else $error("accepted transaction lost at entry");

    // the last compute stage feeds the output when it moves
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && adv[NS]) |=> o_m_axis_tvalid)
        else $error("transaction lost before output");

    // reset empties every stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_v == '0))
        else $error("pipeline not empty after reset");

endmodule
